FILE: rtl/abs_pkg.sv
// Shared types and constants for the alert beeper sequencer.
// The step logic and the top level both take this package by scoped names.
package abs_pkg;

    // Event codes carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RAISE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_BEEP  = 2'd3
    } kind_t;

    // Severity codes.
    localparam logic [1:0] LVL_NOTIFICATION = 2'd0;
    localparam logic [1:0] LVL_WARNING      = 2'd1;
    localparam logic [1:0] LVL_CRITICAL     = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ALWAYS_ON         = 2'd0;
    localparam logic [1:0] REG_NOTIFICATION_LAST = 2'd1;
    localparam logic [1:0] REG_WARNING_LAST      = 2'd2;

    localparam int PATTERN_W       = 12;
    localparam int SHORT_W         = 3;
    localparam int ID_W            = 8;
    localparam int SHORT_BEEP_TICKS_DEF = 4;

    localparam logic [PATTERN_W-1:0] PAT_NOTIFICATION = 12'h00F;
    localparam logic [PATTERN_W-1:0] PAT_WARNING      = 12'h0AA;
    localparam logic [PATTERN_W-1:0] PAT_CRITICAL     = 12'hF0F;

    localparam logic [1:0] LVL_RESET_NOTIFICATION = 2'd0;

    typedef struct packed {
        logic                 run;
        logic [ID_W-1:0]      alert_number;
        logic [1:0]           alert_level;
        logic [PATTERN_W-1:0] beep_pattern;
        logic [SHORT_W-1:0]   short_left;
        logic                 beeper;
    } seq_state_t;

    typedef struct packed {
        logic            beeper;
        logic            operational;
        logic            display_restart;
        logic            alert_changed;
        logic [ID_W-1:0] active_id;
        logic [1:0]      active_level;
    } result_t;

    typedef struct packed {
        logic            always_on;
        logic [ID_W-1:0] notification_last_id;
        logic [ID_W-1:0] warning_last_id;
    } cfg_t;

endpackage

FILE: rtl/abs_step.sv
// Next-state and result logic for one event of the alert beeper sequencer.
// Purely combinational; uses types and constants from abs_pkg.
module abs_step #(
    parameter int SHORT_BEEP_TICKS = abs_pkg::SHORT_BEEP_TICKS_DEF
) (
    input  abs_pkg::cfg_t          cfg,
    input  abs_pkg::seq_state_t    cur,
    input  abs_pkg::kind_t         kind,
    input  logic [abs_pkg::ID_W-1:0] alert_id,
    input  logic                   board_enabled,
    output abs_pkg::seq_state_t    nxt,
    output abs_pkg::result_t       result
);

    logic                              restart;
    logic                              changed;
    logic                              run_new;
    logic                              beep;
    logic [abs_pkg::PATTERN_W-1:0]     shifted;
    logic [1:0]                        sev;

    // Classify the raised id against the two boundaries.
    always_comb begin
        if (alert_id > cfg.notification_last_id) begin
            sev = (alert_id > cfg.warning_last_id) ? abs_pkg::LVL_CRITICAL
                                                   : abs_pkg::LVL_WARNING;
        end else begin
            sev = abs_pkg::LVL_NOTIFICATION;
        end
    end

    always_comb begin
        nxt     = cur;
        restart = 1'b0;
        changed = 1'b0;
        run_new = cur.run;
        beep    = 1'b0;
        shifted = cur.beep_pattern >> 1;
        case (kind)
            abs_pkg::KIND_TICK: begin
                if (cfg.always_on) begin
                    run_new = 1'b1;
                end else if (!cur.run && board_enabled) begin
                    run_new = 1'b1;
                    restart = 1'b1;
                end else if (cur.run && !board_enabled) begin
                    run_new = 1'b0;
                end
                nxt.run = run_new;
                // The beeper step uses the run state updated by this same tick.
                if (run_new) begin
                    if (cur.beep_pattern != '0) begin
                        beep             = cur.beep_pattern[0];
                        nxt.beep_pattern = shifted;
                        if (shifted == '0) begin
                            nxt.alert_number = '0;
                            nxt.alert_level  = abs_pkg::LVL_RESET_NOTIFICATION;
                        end
                    end
                    if (cur.short_left != '0) begin
                        nxt.short_left = cur.short_left - 1'b1;
                        beep           = 1'b1;
                    end
                    nxt.beeper = beep;
                end
            end
            abs_pkg::KIND_RAISE: begin
                if (cur.alert_level <= sev) begin
                    nxt.alert_number = alert_id;
                    nxt.alert_level  = sev;
                    case (sev)
                        abs_pkg::LVL_NOTIFICATION: nxt.beep_pattern = abs_pkg::PAT_NOTIFICATION;
                        abs_pkg::LVL_WARNING:      nxt.beep_pattern = abs_pkg::PAT_WARNING;
                        default:                   nxt.beep_pattern = abs_pkg::PAT_CRITICAL;
                    endcase
                    changed = 1'b1;
                end
            end
            abs_pkg::KIND_CLEAR: begin
                nxt.alert_number = '0;
                nxt.alert_level  = abs_pkg::LVL_RESET_NOTIFICATION;
                nxt.beep_pattern = '0;
            end
            default: begin
                nxt.short_left = abs_pkg::SHORT_W'(SHORT_BEEP_TICKS);
            end
        endcase
    end

    always_comb begin
        result.beeper          = nxt.beeper;
        result.operational     = nxt.run;
        result.display_restart = restart;
        result.alert_changed   = changed;
        result.active_id       = nxt.alert_number;
        result.active_level    = nxt.alert_level;
    end

endmodule

FILE: rtl/alert_beeper_sequencer.sv
// Alert beeper sequencer: classifies raised alerts, runs beep patterns on ticks.
// Depends on abs_pkg and instantiates abs_step.
//
// The block takes one event per clock cycle while the result side is ready and
// returns exactly one result per event. An accepted event is held in an input
// register until the result register is free, then the step logic applies it
// to the state and writes the result register, so each result passes through
// the input register and then the result register. A waiting result leaves room
// for one more event in the input register; further requests are held off until
// the result is taken. Sustained throughput is one event per cycle while the
// result side is ready, set by the combinational step logic.
// Registers: always_on at 0x0, notification_last_id at 0x4, warning_last_id
// at 0x8; write them only while no event is in flight.
module alert_beeper_sequencer #(
    parameter int SHORT_BEEP_TICKS = abs_pkg::SHORT_BEEP_TICKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input events.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] alert_id, [8] board_enabled, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] beeper, [1] operational,
                                        // [2] display_restart, [3] alert_changed,
                                        // [11:4] active_id, [13:12] active_level
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    abs_pkg::cfg_t                 cfg_reg;
    abs_pkg::seq_state_t           state_reg;
    abs_pkg::seq_state_t           state_next;
    abs_pkg::result_t              result_next;
    abs_pkg::result_t              out_reg;
    logic                          out_valid_reg;
    logic                          in_valid_reg;
    abs_pkg::kind_t                in_kind_reg;
    logic [abs_pkg::ID_W-1:0]      in_id_reg;
    logic                          in_enabled_reg;
    logic                          advance;
    logic                          cfg_write;
    logic [1:0]                    reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.always_on            <= 1'b0;
            cfg_reg.notification_last_id <= 8'd63;
            cfg_reg.warning_last_id      <= 8'd127;
        end else if (cfg_write) begin
            case (reg_index)
                abs_pkg::REG_ALWAYS_ON:         cfg_reg.always_on            <= pwdata[0];
                abs_pkg::REG_NOTIFICATION_LAST: cfg_reg.notification_last_id <= pwdata[7:0];
                abs_pkg::REG_WARNING_LAST:      cfg_reg.warning_last_id      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            abs_pkg::REG_ALWAYS_ON:         prdata = {31'd0, cfg_reg.always_on};
            abs_pkg::REG_NOTIFICATION_LAST: prdata = {24'd0, cfg_reg.notification_last_id};
            abs_pkg::REG_WARNING_LAST:      prdata = {24'd0, cfg_reg.warning_last_id};
            default:                        prdata = '0;
        endcase
    end

    // The held request moves to the result register whenever that slot frees up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_kind_reg    <= abs_pkg::kind_t'(s_axis_tuser);
            in_id_reg      <= s_axis_tdata[7:0];
            in_enabled_reg <= s_axis_tdata[8];
        end
    end

    abs_step #(
        .SHORT_BEEP_TICKS(SHORT_BEEP_TICKS)
    ) u_step (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .kind         (in_kind_reg),
        .alert_id     (in_id_reg),
        .board_enabled(in_enabled_reg),
        .nxt          (state_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.active_level, out_reg.active_id,
                            out_reg.alert_changed, out_reg.display_restart,
                            out_reg.operational, out_reg.beeper};

    // An empty pattern always goes with no active alert.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.beep_pattern == '0 |->
            (state_reg.alert_number == '0 && state_reg.alert_level == '0))
        else $error("beep pattern empty while an alert is active");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.alert_level != 2'd3)
        else $error("alert level holds an unused code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_kind_reg == abs_pkg::KIND_CLEAR |=>
            (out_reg.active_id == '0 && out_reg.active_level == '0 && out_valid_reg))
        else $error("clear request did not clear the active alert");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_kind_reg == abs_pkg::KIND_TICK && cfg_reg.always_on |=>
            (state_reg.run && !out_reg.display_restart))
        else $error("always-on tick left the block idle or pulsed restart");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.display_restart |-> out_reg.operational)
        else $error("display restart without operational state");

endmodule
